// File: design/source_byte_tokenizer_unit_defines.svh
// Assertion macros shared by the tokenizer RTL.
`ifndef SOURCE_BYTE_TOKENIZER_UNIT_DEFINES_SVH
`define SOURCE_BYTE_TOKENIZER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define SBT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define SBT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SBT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define SBT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// File: design/sbt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sbt_pkg;

    localparam int OFFSET_BITS = 24;
    localparam int LEN_W       = (OFFSET_BITS > 24) ? OFFSET_BITS : 24;

    typedef logic [OFFSET_BITS-1:0] offset_t;

    localparam offset_t     OFF_MAX = '1;
    localparam logic [23:0] F24_MAX = '1;

    // token kinds
    localparam logic [3:0] K_ILLEGAL = 4'd0;
    localparam logic [3:0] K_EOF     = 4'd1;
    localparam logic [3:0] K_IDENT   = 4'd2;
    localparam logic [3:0] K_INT     = 4'd3;
    localparam logic [3:0] K_ASSIGN  = 4'd4;
    localparam logic [3:0] K_SEMI    = 4'd5;
    localparam logic [3:0] K_LPAREN  = 4'd6;
    localparam logic [3:0] K_RPAREN  = 4'd7;
    localparam logic [3:0] K_LBRACE  = 4'd8;
    localparam logic [3:0] K_RBRACE  = 4'd9;
    localparam logic [3:0] K_PLUS    = 4'd10;
    localparam logic [3:0] K_MINUS   = 4'd11;
    localparam logic [3:0] K_COMMA   = 4'd12;
    localparam logic [3:0] K_FN      = 4'd13;
    localparam logic [3:0] K_LET     = 4'd14;
    localparam logic [3:0] K_RETURN  = 4'd15;

    // bytes with special meaning
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    localparam logic [7:0] ZW_BYTE0  = 8'hE2;
    localparam logic [7:0] ZW_BYTE1  = 8'h80;
    localparam logic [7:0] ZW_BYTE2  = 8'h8B;
    localparam logic [7:0] BOM_BYTE0 = 8'hEF;
    localparam logic [7:0] BOM_BYTE1 = 8'hBB;
    localparam logic [7:0] BOM_BYTE2 = 8'hBF;

    typedef enum logic [3:0] {
        M_BOM0,
        M_BOM1,
        M_BOM2,
        M_IDLE,
        M_IDENT,
        M_INT,
        M_ZW1,
        M_ZW2,
        M_DONE
    } scan_mode_t;

    typedef struct packed {
        logic [3:0]  kind;
        logic [23:0] start;
        logic [23:0] len;
        logic [23:0] line;
        logic        last;
    } token_t;

    function automatic logic is_alpha(logic [7:0] b);
        return (b inside {[8'h61:8'h7A], [8'h41:8'h5A], 8'h5F});
    endfunction

    function automatic logic is_numeric(logic [7:0] b);
        return (b inside {[8'h30:8'h39]});
    endfunction

    function automatic offset_t off_inc(offset_t v);
        return (v == OFF_MAX) ? v : v + offset_t'(1);
    endfunction

    function automatic logic [23:0] to_f24(offset_t v);
        logic [LEN_W-1:0] w;
        w = LEN_W'(v);
        return w[23:0];
    endfunction

    function automatic logic [23:0] sat_len(offset_t v);
        logic [LEN_W-1:0] w;
        w = LEN_W'(v);
        return (w > LEN_W'(F24_MAX)) ? F24_MAX : w[23:0];
    endfunction

    // keyword 0 = fn, 1 = let, 2 = return
    function automatic logic [2:0] kw_len(logic [1:0] k);
        case (k)
            2'd0:    return 3'd2;
            2'd1:    return 3'd3;
            default: return 3'd6;
        endcase
    endfunction

    function automatic logic [3:0] kw_kind(logic [1:0] k);
        case (k)
            2'd0:    return K_FN;
            2'd1:    return K_LET;
            default: return K_RETURN;
        endcase
    endfunction

    function automatic logic [7:0] kw_char(logic [1:0] k, logic [2:0] i);
        case ({k, i})
            5'b00_000: return 8'h66; // f
            5'b00_001: return 8'h6E; // n
            5'b01_000: return 8'h6C; // l
            5'b01_001: return 8'h65; // e
            5'b01_010: return 8'h74; // t
            5'b10_000: return 8'h72; // r
            5'b10_001: return 8'h65; // e
            5'b10_010: return 8'h74; // t
            5'b10_011: return 8'h75; // u
            5'b10_100: return 8'h72; // r
            5'b10_101: return 8'h6E; // n
            default:   return 8'h00;
        endcase
    endfunction

    function automatic logic [2:0] kw_narrow(logic [2:0] cand, logic [7:0] b, offset_t idx);
        logic [2:0] res;
        res = cand;
        for (int k = 0; k < 3; k++) begin
            if (idx >= offset_t'(kw_len(2'(k))) || kw_char(2'(k), idx[2:0]) != b)
            begin
                res[k] = 1'b0;
            end
        end
        return res;
    endfunction

    function automatic logic [3:0] word_kind(logic [2:0] cand, offset_t len);
        logic [3:0] kind;
        kind = K_IDENT;
        for (int k = 0; k < 3; k++) begin
            if (cand[k] && len == offset_t'(kw_len(2'(k))))
            begin
                kind = kw_kind(2'(k));
            end
        end
        return kind;
    endfunction

endpackage

`default_nettype wire

// File: design/sbt_byte_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface sbt_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_input;

    modport source (output valid, output data_byte, output end_of_input, input ready);
    modport sink   (input valid, input data_byte, input end_of_input, output ready);
endinterface

`default_nettype wire

// File: design/sbt_token_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface sbt_token_if;
    logic        valid;
    logic        ready;
    logic [3:0]  token_kind;
    logic [23:0] start_offset;
    logic [23:0] token_length;
    logic [23:0] line_number;
    logic        last_of_run;

    modport source (output valid, output token_kind, output start_offset,
                    output token_length, output line_number, output last_of_run,
                    input ready);
    modport sink   (input valid, input token_kind, input start_offset,
                    input token_length, input line_number, input last_of_run,
                    output ready);
endinterface

`default_nettype wire

// File: design/source_byte_tokenizer_unit.sv
// Source byte tokenizer.
// bytes  : one source byte per item (data_byte, end_of_input), valid/ready.
// tokens : one token per item (kind, start offset, length, line, last_of_run).
// A byte is decoded against the scanner state in the cycle it is accepted;
// the 0..3 tokens it causes land in a three-entry result register and show
// on the tokens channel from the next cycle, one per cycle while the receiver
// is ready, with last_of_run on the final one. Throughput: one byte per
// cycle while each byte causes at most one token and the receiver is ready;
// a byte that causes several tokens holds the result register until all
// have gone out the single token output; tokenless bytes never hold it.
// A byte is taken whenever the result register is empty or its last token
// leaves in the same cycle, so a stalled receiver holds off the byte side
// as soon as any token is waiting.
// end_of_input flushes the open token, emits EOF (unless a NUL already did)
// and returns the scanner to its reset state for the next stream.
// Reset: result register empty, offset 0, line 1, BOM check armed.
`timescale 1ns / 1ps
`default_nettype none
`include "source_byte_tokenizer_unit_defines.svh"

module source_byte_tokenizer_unit
    import sbt_pkg::*;
(
    input  wire            clk,
    input  wire            rst_n,
    sbt_byte_if.sink       bytes,
    sbt_token_if.source    tokens
);

    offset_t     offset_reg,  offset_next;
    logic [23:0] line_reg,    line_next;
    scan_mode_t  mode_reg,    mode_next;
    offset_t     start_reg,   start_next;
    logic [2:0]  kwc_reg,     kwc_next;
    offset_t     held_reg,    held_next;

    token_t      slot_reg [3];
    token_t      slot_next [3];
    logic [1:0]  pend_reg,    pend_next;

    logic        acc;
    logic        pop;
    logic [7:0]  b;
    offset_t     off;

    // decode of a byte seen fresh
    logic        f_emit;
    logic [3:0]  f_kind;
    scan_mode_t  f_mode;
    logic        f_line_inc;
    logic        f_start_set;
    logic        f_held_set;

    logic        use_fresh;
    logic [1:0]  pre_n;
    token_t      pre0, pre1, f_tok;
    token_t      new_tok [3];
    logic [1:0]  new_n;

    assign acc = bytes.valid && bytes.ready;
    assign pop = tokens.valid && tokens.ready;
    assign b   = bytes.end_of_input ? CH_NUL : bytes.data_byte;
    assign off = offset_reg;

    assign bytes.ready         = (pend_reg == 2'd0) || (pend_reg == 2'd1 && tokens.ready);
    assign tokens.valid        = (pend_reg != 2'd0);
    assign tokens.token_kind   = slot_reg[0].kind;
    assign tokens.start_offset = slot_reg[0].start;
    assign tokens.token_length = slot_reg[0].len;
    assign tokens.line_number  = slot_reg[0].line;
    assign tokens.last_of_run  = slot_reg[0].last;

    always_comb
    begin
        f_emit      = 1'b0;
        f_kind      = K_ILLEGAL;
        f_mode      = M_IDLE;
        f_line_inc  = 1'b0;
        f_start_set = 1'b0;
        f_held_set  = 1'b0;
        case (b)
            CH_NUL:
            begin
                f_emit = 1'b1;
                f_kind = K_EOF;
                f_mode = M_DONE;
            end
            CH_SPACE, CH_TAB, CH_CR: ;
            CH_LF:     f_line_inc = 1'b1;
            ZW_BYTE0:
            begin
                f_mode     = M_ZW1;
                f_held_set = 1'b1;
            end
            CH_EQUAL:  begin f_emit = 1'b1; f_kind = K_ASSIGN; end
            CH_SEMI:   begin f_emit = 1'b1; f_kind = K_SEMI;   end
            CH_LPAREN: begin f_emit = 1'b1; f_kind = K_LPAREN; end
            CH_RPAREN: begin f_emit = 1'b1; f_kind = K_RPAREN; end
            CH_LBRACE: begin f_emit = 1'b1; f_kind = K_LBRACE; end
            CH_RBRACE: begin f_emit = 1'b1; f_kind = K_RBRACE; end
            CH_PLUS:   begin f_emit = 1'b1; f_kind = K_PLUS;   end
            CH_MINUS:  begin f_emit = 1'b1; f_kind = K_MINUS;  end
            CH_COMMA:  begin f_emit = 1'b1; f_kind = K_COMMA;  end
            default:
            begin
                if (is_alpha(b))
                begin
                    f_mode      = M_IDENT;
                    f_start_set = 1'b1;
                end
                else if (is_numeric(b))
                begin
                    f_mode      = M_INT;
                    f_start_set = 1'b1;
                end
                else
                begin
                    f_emit = 1'b1;
                end
            end
        endcase
        f_tok.kind  = f_kind;
        f_tok.start = to_f24(off);
        f_tok.len   = (f_kind == K_EOF) ? 24'd0 : 24'd1;
        f_tok.line  = line_reg;
        f_tok.last  = 1'b0;
    end

    always_comb
    begin
        mode_next  = mode_reg;
        line_next  = line_reg;
        start_next = start_reg;
        kwc_next   = kwc_reg;
        held_next  = held_reg;
        use_fresh  = 1'b0;
        pre_n      = 2'd0;

        pre0.kind  = K_ILLEGAL;
        pre0.start = to_f24(held_reg);
        pre0.len   = 24'd1;
        pre0.line  = line_reg;
        pre0.last  = 1'b0;
        pre1.kind  = K_ILLEGAL;
        pre1.start = to_f24(off_inc(held_reg));
        pre1.len   = 24'd1;
        pre1.line  = line_reg;
        pre1.last  = 1'b0;

        case (mode_reg)
            M_BOM0:
            begin
                if (b == BOM_BYTE0)
                begin
                    mode_next = M_BOM1;
                    held_next = off;
                end
                else
                begin
                    use_fresh = 1'b1;
                end
            end
            M_BOM1, M_ZW1:
            begin
                if (mode_reg == M_BOM1 && b == BOM_BYTE1)
                    mode_next = M_BOM2;
                else if (mode_reg == M_ZW1 && b == ZW_BYTE1)
                    mode_next = M_ZW2;
                else
                begin
                    pre_n     = 2'd1;
                    use_fresh = 1'b1;
                end
            end
            M_BOM2, M_ZW2:
            begin
                if ((mode_reg == M_BOM2 && b == BOM_BYTE2)
                    || (mode_reg == M_ZW2 && b == ZW_BYTE2))
                    mode_next = M_IDLE;
                else
                begin
                    pre_n     = 2'd2;
                    use_fresh = 1'b1;
                end
            end
            M_IDENT:
            begin
                if (is_alpha(b) || is_numeric(b))
                    kwc_next = kw_narrow(kwc_reg, b, off - start_reg);
                else
                begin
                    pre_n      = 2'd1;
                    pre0.kind  = word_kind(kwc_reg, off - start_reg);
                    pre0.start = to_f24(start_reg);
                    pre0.len   = sat_len(off - start_reg);
                    use_fresh  = 1'b1;
                end
            end
            M_INT:
            begin
                if (!is_numeric(b))
                begin
                    pre_n      = 2'd1;
                    pre0.kind  = K_INT;
                    pre0.start = to_f24(start_reg);
                    pre0.len   = sat_len(off - start_reg);
                    use_fresh  = 1'b1;
                end
            end
            M_DONE: ;
            default: use_fresh = 1'b1;
        endcase

        if (use_fresh)
        begin
            mode_next = f_mode;
            if (f_line_inc && line_reg != F24_MAX)
                line_next = line_reg + 24'd1;
            if (f_start_set)
            begin
                start_next = off;
                kwc_next   = kw_narrow(3'b111, b, '0);
            end
            if (f_held_set)
                held_next = off;
        end

        // pack prefix tokens, then the fresh token
        new_n      = pre_n + {1'b0, use_fresh && f_emit};
        new_tok[0] = (pre_n != 2'd0) ? pre0 : f_tok;
        new_tok[1] = (pre_n == 2'd2) ? pre1 : f_tok;
        new_tok[2] = f_tok;
        new_tok[0].last = (new_n == 2'd1);
        new_tok[1].last = (new_n == 2'd2);
        new_tok[2].last = (new_n == 2'd3);
    end

    always_comb
    begin
        slot_next = slot_reg;
        pend_next = pend_reg;
        if (acc)
        begin
            slot_next = new_tok;
            pend_next = new_n;
        end
        else if (pop)
        begin
            slot_next[0] = slot_reg[1];
            slot_next[1] = slot_reg[2];
            pend_next    = pend_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= '0;
            line_reg   <= 24'd1;
            mode_reg   <= M_BOM0;
            start_reg  <= '0;
            kwc_reg    <= 3'b111;
            held_reg   <= '0;
            pend_reg   <= 2'd0;
        end
        else
        begin
            pend_reg <= pend_next;
            if (acc)
            begin
                if (bytes.end_of_input)
                begin
                    offset_reg <= '0;
                    line_reg   <= 24'd1;
                    mode_reg   <= M_BOM0;
                    start_reg  <= '0;
                    kwc_reg    <= 3'b111;
                    held_reg   <= '0;
                end
                else
                begin
                    offset_reg <= off_inc(offset_reg);
                    line_reg   <= line_next;
                    mode_reg   <= mode_next;
                    start_reg  <= start_next;
                    kwc_reg    <= kwc_next;
                    held_reg   <= held_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

    `SBT_ASSERT_IMP(a_eof_last, clk, rst_n, tokens.valid && tokens.token_kind == K_EOF, tokens.token_length == 24'd0 && tokens.last_of_run, "EOF token must be last with zero length")
    `SBT_ASSERT_IMP(a_tail_last, clk, rst_n, pend_reg == 2'd1, slot_reg[0].last, "final pending token lacks last_of_run")
    `SBT_ASSERT_IMP(a_line_nonzero, clk, rst_n, tokens.valid, tokens.line_number != 24'd0, "line number is zero")
    `SBT_ASSERT_NXT(a_eoi_reset, clk, rst_n, acc && bytes.end_of_input, mode_reg == M_BOM0 && line_reg == 24'd1 && offset_reg == '0, "end of input did not reset scanner")

endmodule

`default_nettype wire

// File: tb/tb_source_byte_tokenizer_unit.sv
`timescale 1ns / 1ps

module tb_source_byte_tokenizer_unit;
    import sbt_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_ITEMS = 400;
    localparam int CALM_ITEMS   = 50;

    typedef struct packed {
        logic [7:0] data;
        logic       eoi;
    } src_byte_t;

    typedef struct {
        logic [7:0] data;
        logic       eoi;
        bit         typed;
        bit         has_tok;
        token_t     tok;
    } row_t;

    typedef struct {
        bit     typed;
        bit     has_tok;
        token_t tok;
    } row_note_t;

    localparam token_t NO_TOK = '0;

    logic clk;
    logic rst_n;

    sbt_byte_if  byte_ch ();
    sbt_token_if tok_ch ();

    source_byte_tokenizer_unit uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .bytes  (byte_ch),
        .tokens (tok_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Tokenizer prediction
    // ------------------------------------------------------------------
    offset_t     lex_pos;
    logic [23:0] lex_line;
    scan_mode_t  lex_state;
    offset_t     word_start;
    logic [2:0]  kw_alive;
    offset_t     prefix_at;
    token_t      step_tokens[$];
    token_t      pending_tokens[$];

    string      kw_word [3] = '{"fn", "let", "return"};
    logic [3:0] kw_tag  [3] = '{K_FN, K_LET, K_RETURN};

    function automatic void lex_reset();
        lex_pos    = '0;
        lex_line   = 24'd1;
        lex_state  = M_BOM0;
        word_start = '0;
        kw_alive   = 3'b111;
        prefix_at  = '0;
    endfunction

    function automatic offset_t step_off(offset_t v);
        return (v == OFF_MAX) ? v : v + 1'b1;
    endfunction

    function automatic bit word_head(logic [7:0] b);
        return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A) || b == 8'h5F;
    endfunction

    function automatic bit is_decimal(logic [7:0] b);
        return b >= 8'h30 && b <= 8'h39;
    endfunction

    // at most three tokens per byte
    function automatic void add_token(logic [3:0] kind, offset_t start, offset_t len);
        token_t t;
        if (step_tokens.size() >= 3)
            return;
        t.kind  = kind;
        t.start = 24'(start);
        t.len   = (64'(len) > 64'(F24_MAX)) ? F24_MAX : 24'(len);
        t.line  = lex_line;
        t.last  = 1'b0;
        step_tokens.push_back(t);
    endfunction

    function automatic void narrow_kw(logic [7:0] b, offset_t idx);
        int k;
        for (k = 0; k < 3; k++)
        begin
            if (idx >= offset_t'(kw_word[k].len()) || 8'(kw_word[k][idx]) != b)
                kw_alive[k] = 1'b0;
        end
    endfunction

    function automatic void close_word(offset_t at);
        offset_t    len;
        logic [3:0] kind;
        int         k;
        len  = at - word_start;
        kind = K_IDENT;
        for (k = 0; k < 3; k++)
        begin
            if (kw_alive[k] && len == offset_t'(kw_word[k].len()))
                kind = kw_tag[k];
        end
        add_token(kind, word_start, len);
    endfunction

    function automatic void lex_fresh(logic [7:0] b, offset_t at);
        lex_state = M_IDLE;
        case (b)
            CH_NUL:
            begin
                add_token(K_EOF, at, '0);
                lex_state = M_DONE;
            end
            CH_SPACE, CH_TAB, CH_CR: ;
            CH_LF:
                if (lex_line != F24_MAX)
                    lex_line = lex_line + 1'b1;
            ZW_BYTE0:
            begin
                lex_state = M_ZW1;
                prefix_at = at;
            end
            CH_EQUAL:  add_token(K_ASSIGN, at, offset_t'(1));
            CH_SEMI:   add_token(K_SEMI, at, offset_t'(1));
            CH_LPAREN: add_token(K_LPAREN, at, offset_t'(1));
            CH_RPAREN: add_token(K_RPAREN, at, offset_t'(1));
            CH_LBRACE: add_token(K_LBRACE, at, offset_t'(1));
            CH_RBRACE: add_token(K_RBRACE, at, offset_t'(1));
            CH_PLUS:   add_token(K_PLUS, at, offset_t'(1));
            CH_MINUS:  add_token(K_MINUS, at, offset_t'(1));
            CH_COMMA:  add_token(K_COMMA, at, offset_t'(1));
            default:
            begin
                if (word_head(b))
                begin
                    lex_state  = M_IDENT;
                    word_start = at;
                    kw_alive   = 3'b111;
                    narrow_kw(b, '0);
                end
                else if (is_decimal(b))
                begin
                    lex_state  = M_INT;
                    word_start = at;
                end
                else
                begin
                    add_token(K_ILLEGAL, at, offset_t'(1));
                end
            end
        endcase
    endfunction

    // held prefix bytes that were not completed become illegal, one each
    function automatic void drop_prefix(int held, logic [7:0] b, offset_t at);
        add_token(K_ILLEGAL, prefix_at, offset_t'(1));
        if (held == 2)
            add_token(K_ILLEGAL, step_off(prefix_at), offset_t'(1));
        lex_fresh(b, at);
    endfunction

    function automatic void lex_take(logic [7:0] b, offset_t at);
        case (lex_state)
            M_BOM0:
            begin
                if (b == BOM_BYTE0)
                begin
                    lex_state = M_BOM1;
                    prefix_at = at;
                end
                else
                begin
                    lex_fresh(b, at);
                end
            end
            M_BOM1:
                if (b == BOM_BYTE1) lex_state = M_BOM2;
                else drop_prefix(1, b, at);
            M_ZW1:
                if (b == ZW_BYTE1) lex_state = M_ZW2;
                else drop_prefix(1, b, at);
            M_BOM2:
                if (b == BOM_BYTE2) lex_state = M_IDLE;
                else drop_prefix(2, b, at);
            M_ZW2:
                if (b == ZW_BYTE2) lex_state = M_IDLE;
                else drop_prefix(2, b, at);
            M_IDENT:
            begin
                if (word_head(b) || is_decimal(b))
                begin
                    narrow_kw(b, at - word_start);
                end
                else
                begin
                    close_word(at);
                    lex_fresh(b, at);
                end
            end
            M_INT:
            begin
                if (!is_decimal(b))
                begin
                    add_token(K_INT, word_start, at - word_start);
                    lex_fresh(b, at);
                end
            end
            M_DONE: ;
            default: lex_fresh(b, at);
        endcase
    endfunction

    function automatic void lex_byte(logic [7:0] b, logic eoi);
        step_tokens.delete();
        if (eoi)
        begin
            // end of input behaves as a NUL unless one was already seen
            if (lex_state != M_DONE)
                lex_take(CH_NUL, lex_pos);
            lex_reset();
        end
        else
        begin
            lex_take(b, lex_pos);
            lex_pos = step_off(lex_pos);
        end
        if (step_tokens.size() > 0)
            step_tokens[step_tokens.size() - 1].last = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Directed rows
    // ------------------------------------------------------------------
    row_t directed_rows [27] = '{
        '{BOM_BYTE0, 1'b0, 1'b1, 1'b0, NO_TOK},
        '{BOM_BYTE1, 1'b0, 1'b0, 1'b0, NO_TOK},
        '{BOM_BYTE2, 1'b0, 1'b0, 1'b0, NO_TOK},
        '{8'h66,     1'b0, 1'b0, 1'b0, NO_TOK},                          // f
        '{8'h6E,     1'b0, 1'b0, 1'b0, NO_TOK},                          // n
        '{CH_SPACE,  1'b0, 1'b1, 1'b1, '{K_FN, 24'd3, 24'd2, 24'd1, 1'b1}},
        '{CH_LF,     1'b0, 1'b0, 1'b0, NO_TOK},
        '{8'h30,     1'b0, 1'b0, 1'b0, NO_TOK},                          // 0
        '{8'h39,     1'b0, 1'b0, 1'b0, NO_TOK},                          // 9
        '{8'h7A,     1'b0, 1'b1, 1'b1, '{K_INT, 24'd7, 24'd2, 24'd2, 1'b1}},
        '{CH_SEMI,   1'b0, 1'b0, 1'b0, NO_TOK},
        '{ZW_BYTE0,  1'b0, 1'b0, 1'b0, NO_TOK},
        '{ZW_BYTE1,  1'b0, 1'b0, 1'b0, NO_TOK},
        '{ZW_BYTE2,  1'b0, 1'b1, 1'b0, NO_TOK},
        '{ZW_BYTE0,  1'b0, 1'b0, 1'b0, NO_TOK},
        '{8'h41,     1'b0, 1'b1, 1'b1, '{K_ILLEGAL, 24'd14, 24'd1, 24'd2, 1'b1}},
        '{8'hFF,     1'b0, 1'b0, 1'b0, NO_TOK},
        '{ZW_BYTE0,  1'b0, 1'b0, 1'b0, NO_TOK},
        '{ZW_BYTE1,  1'b0, 1'b0, 1'b0, NO_TOK},
        '{ZW_BYTE0,  1'b0, 1'b0, 1'b0, NO_TOK},
        '{CH_NUL,    1'b0, 1'b0, 1'b0, NO_TOK},
        '{8'h5F,     1'b0, 1'b1, 1'b0, NO_TOK},                          // after NUL
        '{8'hFF,     1'b1, 1'b1, 1'b0, NO_TOK},
        '{8'h6C,     1'b0, 1'b0, 1'b0, NO_TOK},                          // l
        '{8'h65,     1'b0, 1'b0, 1'b0, NO_TOK},                          // e
        '{8'h74,     1'b0, 1'b0, 1'b0, NO_TOK},                          // t
        '{8'h00,     1'b1, 1'b0, 1'b0, NO_TOK}
    };

    // ------------------------------------------------------------------
    // Random source streams
    // ------------------------------------------------------------------
    src_byte_t random_bytes[$];

    string      word_pool  [12] = '{"fn", "let", "return", "f", "le", "retur", "fnn",
                                    "lets", "return_", "Fn", "r3turn", "_"};
    logic [7:0] punct_pool [9]  = '{CH_EQUAL, CH_SEMI, CH_LPAREN, CH_RPAREN, CH_LBRACE,
                                    CH_RBRACE, CH_PLUS, CH_MINUS, CH_COMMA};
    logic [7:0] blank_pool [4]  = '{CH_SPACE, CH_TAB, CH_CR, CH_LF};
    logic [7:0] odd_pool   [7]  = '{ZW_BYTE0, BOM_BYTE0, ZW_BYTE1, ZW_BYTE2, BOM_BYTE1,
                                    BOM_BYTE2, CH_NUL};

    function automatic void push_src(logic [7:0] b);
        random_bytes.push_back('{b, 1'b0});
    endfunction

    function automatic logic [7:0] word_char(bit first);
        case ($urandom_range(0, first ? 2 : 3))
            0:       return 8'h61 + 8'($urandom_range(0, 25));
            1:       return 8'h41 + 8'($urandom_range(0, 25));
            2:       return ($urandom_range(0, 3) == 0) ? 8'h5F
                                                        : 8'h61 + 8'($urandom_range(0, 25));
            default: return 8'h30 + 8'($urandom_range(0, 9));
        endcase
    endfunction

    function automatic void push_lexeme();
        string w;
        int    n;
        int    i;
        case ($urandom_range(0, 11))
            0:
            begin
                w = word_pool[$urandom_range(0, 11)];
                for (i = 0; i < w.len(); i++)
                    push_src(8'(w[i]));
            end
            1, 2:
            begin
                n = $urandom_range(1, 8);
                push_src(word_char(1'b1));
                for (i = 1; i < n; i++)
                    push_src(word_char(1'b0));
            end
            3:
            begin
                n = $urandom_range(1, 6);
                for (i = 0; i < n; i++)
                    push_src(8'h30 + 8'($urandom_range(0, 9)));
            end
            4, 5, 6: push_src(punct_pool[$urandom_range(0, 8)]);
            7, 11:   push_src(blank_pool[$urandom_range(0, 3)]);
            8:
            begin
                push_src(ZW_BYTE0);
                push_src(ZW_BYTE1);
                push_src(ZW_BYTE2);
            end
            9:
            begin
                // prefix cut short; what follows breaks it unless it happens to complete it
                push_src(ZW_BYTE0);
                if ($urandom_range(0, 1))
                    push_src(ZW_BYTE1);
            end
            default:
                if ($urandom_range(0, 1)) push_src(8'($urandom_range(1, 255)));
                else push_src(odd_pool[$urandom_range(0, 6)]);
        endcase
        if ($urandom_range(0, 1))
            push_src(blank_pool[$urandom_range(0, 3)]);
    endfunction

    function automatic void build_random_streams(int target);
        int n;
        while (random_bytes.size() < target)
        begin
            case ($urandom_range(0, 7))
                0, 1:
                begin
                    push_src(BOM_BYTE0);
                    push_src(BOM_BYTE1);
                    push_src(BOM_BYTE2);
                end
                2:
                begin
                    push_src(BOM_BYTE0);
                    if ($urandom_range(0, 1))
                        push_src(BOM_BYTE1);
                end
                default: ;
            endcase
            n = $urandom_range(2, 24);
            repeat (n) push_lexeme();
            if ($urandom_range(0, 3) == 0)
            begin
                push_src(CH_NUL);
                repeat ($urandom_range(0, 3)) push_src(8'($urandom_range(0, 255)));
            end
            random_bytes.push_back('{8'($urandom_range(0, 255)), 1'b1});
        end
    endfunction

    // ------------------------------------------------------------------
    // Byte side
    // ------------------------------------------------------------------
    row_note_t row_notes[$];
    int        mismatches   = 0;
    int        quiet_cycles = 0;
    bit        hold_req     = 1'b0;
    bit        calm         = 1'b0;

    task automatic offer(src_byte_t it, bit typed, bit has_tok, token_t tok);
        row_notes.push_back('{typed, has_tok, tok});
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            byte_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        byte_ch.valid        <= 1'b1;
        byte_ch.data_byte    <= it.data;
        byte_ch.end_of_input <= it.eoi;
        do @(posedge clk); while (!(byte_ch.valid && byte_ch.ready));
    endtask

    initial
    begin : stimulus
        int i;
        rst_n                <= 1'b0;
        byte_ch.valid        <= 1'b0;
        byte_ch.data_byte    <= 8'h00;
        byte_ch.end_of_input <= 1'b0;
        lex_reset();
        build_random_streams(RANDOM_ITEMS);
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[r])
            offer('{directed_rows[r].data, directed_rows[r].eoi}, directed_rows[r].typed,
                  directed_rows[r].has_tok, directed_rows[r].tok);

        for (i = 0; i < random_bytes.size(); i++)
        begin
            if (i == 30)
                hold_req = 1'b1;
            if (i >= random_bytes.size() - CALM_ITEMS)
                calm = 1'b1;
            offer(random_bytes[i], 1'b0, 1'b0, NO_TOK);
        end
        byte_ch.valid <= 1'b0;

        @(negedge clk);
        while (pending_tokens.size() != 0) @(negedge clk);
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("tb_source_byte_tokenizer_unit OK");
        else
            $display("tb_source_byte_tokenizer_unit NOT OK");
        $finish;
    end

    // ------------------------------------------------------------------
    // Token side
    // ------------------------------------------------------------------
    initial
    begin : receiver
        tok_ch.ready <= 1'b0;
        while (rst_n !== 1'b1) @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                // long hold-off so the result register fills and bytes back up
                hold_req = 1'b0;
                tok_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (!calm && $urandom_range(0, 2) == 0)
            begin
                tok_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
            tok_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
    end

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin : monitor
        row_note_t note;
        token_t    want;
        token_t    got;
        bit        moved;
        moved = 1'b0;
        if (rst_n)
        begin
            if (tok_ch.valid && tok_ch.ready)
            begin
                moved = 1'b1;
                got   = '{tok_ch.token_kind, tok_ch.start_offset, tok_ch.token_length,
                          tok_ch.line_number, tok_ch.last_of_run};
                if (pending_tokens.size() == 0)
                begin
                    $error("token with nothing expected: kind %0d start %0d",
                           got.kind, got.start);
                    mismatches++;
                end
                else
                begin
                    want = pending_tokens.pop_front();
                    check_field("token_kind", want.kind, got.kind);
                    check_field("start_offset", want.start, got.start);
                    check_field("token_length", want.len, got.len);
                    check_field("line_number", want.line, got.line);
                    check_field("last_of_run", want.last, got.last);
                end
            end
            if (byte_ch.valid && byte_ch.ready)
            begin
                moved = 1'b1;
                note  = row_notes.pop_front();
                lex_byte(byte_ch.data_byte, byte_ch.end_of_input);
                if (note.typed)
                begin
                    step_tokens.delete();
                    if (note.has_tok)
                        step_tokens.push_back(note.tok);
                end
                foreach (step_tokens[k])
                    pending_tokens.push_back(step_tokens[k]);
            end
        end
        quiet_cycles <= moved ? 0 : quiet_cycles + 1;
    end

    initial
    begin : watchdog
        while (quiet_cycles < STALL_LIMIT) @(posedge clk);
        $display("tb_source_byte_tokenizer_unit NOT OK");
        $finish;
    end

endmodule
